@@ src/ddo_pkg.sv @@
// Shared types, constants and helpers for the differential drive odometry block.
// Used by ddo_cordic, ddo_div and diff_drive_odometry_unit.
package ddo_pkg;

  // Configuration register indexes
  localparam logic REG_DIST_PER_TICK  = 1'b0;
  localparam logic REG_TURN_PER_METER = 1'b1;

  localparam logic [31:0] DIST_PER_TICK_RST  = 32'd3748552;
  localparam logic [31:0] TURN_PER_METER_RST = 32'd2278550919;

  // CORDIC datapath width and fixed gain (Q2.30)
  localparam int CW_W = 34;
  localparam logic signed [CW_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Velocity scale factors: 1000 ms/s and 2*pi*1000 in Q16
  localparam logic [31:0] LIN_SCALE = 32'd1000;
  localparam logic [31:0] ANG_SCALE = 32'd411774832;

  // Divider widths
  localparam int NUM_W = 64;
  localparam int DEN_W = 16;

  typedef struct packed {
    logic                   done;
    logic signed [CW_W-1:0] cos_v;
    logic signed [CW_W-1:0] sin_v;
  } cordic_res_t;

  // Arctangent table in 2^-32 turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q2.30 to Q1.15 with round half up and clamp
  function automatic logic [15:0] to_q15(input logic signed [CW_W-1:0] v);
    logic signed [CW_W:0] t;
    logic signed [19:0]   q;
    t = (CW_W+1)'(v) + 35'sd16384;
    q = 20'(t >>> 15);
    if (q > 20'sd32767) begin
      return 16'h7FFF;
    end else if (q < -20'sd32768) begin
      return 16'h8000;
    end
    return q[15:0];
  endfunction

endpackage

@@ src/diff_drive_odometry_unit.sv @@
// Differential drive odometry: pose integration, quaternion and velocities.
// Depends on ddo_pkg, ddo_cordic and ddo_div.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready | enc_left, enc_right, elapsed_ms
//  out_    | out | out_tvalid/out_tready | pos_x, pos_y, heading, quat, vels
//  cfg_    | in  | cfg_we                | cfg_index selects register
//
// Most of the time from the accepting edge to the result store goes to the two
// 64-step velocity divisions and the two CORDIC passes; with zero elapsed time
// the divisions are skipped.
// in_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its final store waits for out_tready.
// rst_n is synchronous and active low; it restores registers and pose.
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // enc_left, enc_right, elapsed_ms
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // pos_x, pos_y, heading_angle, quat_z,
                                   // quat_w, lin_vel, ang_vel
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_M0   = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_M3   = 5'd4;
  localparam logic [4:0] ST_M4   = 5'd5;
  localparam logic [4:0] ST_M5   = 5'd6;
  localparam logic [4:0] ST_CS   = 5'd7;
  localparam logic [4:0] ST_CW   = 5'd8;
  localparam logic [4:0] ST_A0   = 5'd9;
  localparam logic [4:0] ST_A1   = 5'd10;
  localparam logic [4:0] ST_A2   = 5'd11;
  localparam logic [4:0] ST_A3   = 5'd12;
  localparam logic [4:0] ST_A4   = 5'd13;
  localparam logic [4:0] ST_HD   = 5'd14;
  localparam logic [4:0] ST_QS   = 5'd15;
  localparam logic [4:0] ST_QW   = 5'd16;
  localparam logic [4:0] ST_V0   = 5'd17;
  localparam logic [4:0] ST_V1   = 5'd18;
  localparam logic [4:0] ST_V2   = 5'd19;
  localparam logic [4:0] ST_V3   = 5'd20;
  localparam logic [4:0] ST_V4   = 5'd21;
  localparam logic [4:0] ST_V5   = 5'd22;
  localparam logic [4:0] ST_DS   = 5'd23;
  localparam logic [4:0] ST_DW   = 5'd24;
  localparam logic [4:0] ST_DN   = 5'd25;

  logic [4:0]   state_r, state_nxt;

  logic [31:0]  dpt_r, tpm_r;
  logic [31:0]  prev_l_r, prev_rt_r;
  logic [31:0]  x_acc_r, y_acc_r, head_r;

  logic [32:0]  smag_r, wdif_r;
  logic         dneg_r, tneg_r;
  logic [15:0]  ms_r;
  logic [62:0]  dmag_r;
  logic [63:0]  wmag_r, thmag_r;
  logic [47:0]  tmp_r;
  logic [63:0]  prod_r;
  logic [31:0]  cmag_r;
  logic         fneg_r;
  logic [47:0]  inc_r;
  logic         sel_r, dsel_r;
  logic [63:0]  numl_r, numa_r;
  logic [15:0]  quat_z_r, quat_w_r;
  logic [31:0]  lin_r, ang_r;
  logic [191:0] out_tdata_r;
  logic         out_tvalid_r;

  logic         in_acc;
  logic         out_load;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;

  logic signed [32:0] dl_s, dr_s, sum_s, dif_s;
  logic [31:0]  half_th, mid_ang;
  logic         c_start;
  logic [31:0]  c_ang;
  ddo_pkg::cordic_res_t cres;
  logic signed [ddo_pkg::CW_W-1:0] f_sel, f_abs;

  logic [31:0]  acc_sel;
  logic signed [49:0] acc_s, inc_s, v_sum;
  logic [31:0]  sat_val;

  logic         d_start, d_done;
  logic [63:0]  d_quot;
  logic         vneg;
  logic [63:0]  vcap, vmag;
  logic [31:0]  vres;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DN) && (!out_tvalid_r || out_tready);

  // Wrapped tick deltas, their sum and difference
  always_comb begin
    dl_s  = signed'({1'b0, in_tdata[31:0] - prev_l_r});
    dr_s  = signed'({1'b0, in_tdata[63:32] - prev_rt_r});
    dl_s  = signed'({dl_s[31], dl_s[31:0]});
    dr_s  = signed'({dr_s[31], dr_s[31:0]});
    sum_s = dl_s + dr_s;
    dif_s = dr_s - dl_s;
  end

  // Shared 32x32 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_M0:   begin mul_a = smag_r[31:0];           mul_b = dpt_r; end
      ST_M1:   begin mul_a = wdif_r[31:0];           mul_b = dpt_r; end
      ST_M3:   begin mul_a = wmag_r[31:0];           mul_b = tpm_r; end
      ST_M4:   begin mul_a = wmag_r[63:32];          mul_b = tpm_r; end
      ST_A1:   begin mul_a = dmag_r[31:0];           mul_b = cmag_r; end
      ST_A2:   begin mul_a = {1'b0, dmag_r[62:32]};  mul_b = cmag_r; end
      ST_V0:   begin mul_a = dmag_r[31:0];           mul_b = ddo_pkg::LIN_SCALE; end
      ST_V1:   begin mul_a = {1'b0, dmag_r[62:32]};  mul_b = ddo_pkg::LIN_SCALE; end
      ST_V3:   begin mul_a = thmag_r[31:0];          mul_b = ddo_pkg::ANG_SCALE; end
      ST_V4:   begin mul_a = thmag_r[63:32];         mul_b = ddo_pkg::ANG_SCALE; end
      default: begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // Mid-step heading and CORDIC requests
  assign half_th = thmag_r[32:1];
  assign mid_ang = tneg_r ? head_r - half_th : head_r + half_th;
  assign c_start = (state_r == ST_CS) || (state_r == ST_QS);
  assign c_ang   = (state_r == ST_CS) ? mid_ang : {1'b0, head_r[31:1]};

  ddo_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(c_start),
    .ang_i  (c_ang),
    .res_o  (cres)
  );

  assign f_sel = sel_r ? cres.sin_v : cres.cos_v;
  assign f_abs = f_sel[ddo_pkg::CW_W-1] ? -f_sel : f_sel;

  // Position update with saturation
  always_comb begin
    acc_sel = sel_r ? y_acc_r : x_acc_r;
    acc_s   = signed'({{18{acc_sel[31]}}, acc_sel});
    inc_s   = signed'({2'b00, inc_r});
    v_sum   = (dneg_r ^ fneg_r) ? acc_s - inc_s : acc_s + inc_s;
    if (v_sum > 50'sd2147483647) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (v_sum < -50'sd2147483648) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = v_sum[31:0];
    end
  end

  // Velocity divider
  assign d_start = (state_r == ST_DS) && (ms_r != '0);

  ddo_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(d_start),
    .num_i  (dsel_r ? numa_r : numl_r),
    .den_i  (ms_r),
    .done_o (d_done),
    .quot_o (d_quot)
  );

  always_comb begin
    vneg = dsel_r ? tneg_r : dneg_r;
    vcap = vneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    vmag = (d_quot > vcap) ? vcap : d_quot;
    vres = vneg ? -vmag[31:0] : vmag[31:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_CS;
      ST_CS:   state_nxt = ST_CW;
      ST_CW:   if (cres.done) state_nxt = ST_A0;
      ST_A0:   state_nxt = ST_A1;
      ST_A1:   state_nxt = ST_A2;
      ST_A2:   state_nxt = ST_A3;
      ST_A3:   state_nxt = ST_A4;
      ST_A4:   state_nxt = sel_r ? ST_HD : ST_A0;
      ST_HD:   state_nxt = ST_QS;
      ST_QS:   state_nxt = ST_QW;
      ST_QW:   if (cres.done) state_nxt = ST_V0;
      ST_V0:   state_nxt = ST_V1;
      ST_V1:   state_nxt = ST_V2;
      ST_V2:   state_nxt = ST_V3;
      ST_V3:   state_nxt = ST_V4;
      ST_V4:   state_nxt = ST_V5;
      ST_V5:   state_nxt = ST_DS;
      ST_DS:   state_nxt = (ms_r == '0) ? ST_DN : ST_DW;
      ST_DW:   if (d_done) state_nxt = dsel_r ? ST_DN : ST_DS;
      ST_DN:   if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dpt_r        <= ddo_pkg::DIST_PER_TICK_RST;
      tpm_r        <= ddo_pkg::TURN_PER_METER_RST;
      prev_l_r     <= '0;
      prev_rt_r    <= '0;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      head_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ddo_pkg::REG_DIST_PER_TICK:  dpt_r <= cfg_data;
          ddo_pkg::REG_TURN_PER_METER: tpm_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_l_r  <= in_tdata[31:0];
        prev_rt_r <= in_tdata[63:32];
      end
      if (state_r == ST_A4) begin
        if (sel_r) y_acc_r <= sat_val;
        else       x_acc_r <= sat_val;
      end
      if (state_r == ST_HD) begin
        head_r <= tneg_r ? head_r - thmag_r[31:0] : head_r + thmag_r[31:0];
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dneg_r <= sum_s[32];
      tneg_r <= dif_s[32];
      smag_r <= sum_s[32] ? 33'(-sum_s) : 33'(sum_s);
      wdif_r <= dif_s[32] ? 33'(-dif_s) : 33'(dif_s);
      ms_r   <= in_tdata[79:64];
    end
    case (state_r)
      ST_M1: dmag_r  <= 63'((prod_r + (smag_r[32] ? {dpt_r, 32'd0} : 64'd0)) >> 1);
      ST_M2: wmag_r  <= prod_r + (wdif_r[32] ? {dpt_r, 32'd0} : 64'd0);
      ST_M4: tmp_r   <= {16'd0, prod_r[63:32]};
      ST_M5: thmag_r <= prod_r + {32'd0, tmp_r[31:0]};
      ST_CS: sel_r   <= 1'b0;
      ST_A0: begin
        fneg_r <= f_sel[ddo_pkg::CW_W-1];
        cmag_r <= f_abs[31:0];
      end
      ST_A2: tmp_r <= {16'd0, prod_r[63:32]};
      ST_A3: inc_r <= 48'((prod_r + {32'd0, tmp_r[31:0]}) >> 14);
      ST_A4: sel_r <= 1'b1;
      ST_QW: begin
        if (cres.done) begin
          quat_z_r <= ddo_pkg::to_q15(cres.sin_v);
          quat_w_r <= ddo_pkg::to_q15(cres.cos_v);
        end
      end
      ST_V1: tmp_r  <= prod_r[63:16];
      ST_V2: numl_r <= {prod_r[47:0], 16'd0} + {16'd0, tmp_r};
      ST_V4: tmp_r  <= {16'd0, prod_r[63:32]};
      ST_V5: begin
        numa_r <= prod_r + {32'd0, tmp_r[31:0]};
        dsel_r <= 1'b0;
      end
      ST_DS: begin
        if (ms_r == '0) begin
          lin_r <= '0;
          ang_r <= '0;
        end
      end
      ST_DW: begin
        if (d_done) begin
          if (dsel_r) ang_r <= vres;
          else        lin_r <= vres;
          dsel_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_tdata_r <= {ang_r, lin_r, quat_w_r, quat_z_r, head_r, y_acc_r, x_acc_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request accepted but sequencer still ready");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("result store did not raise out_tvalid");

  a_zero_time_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DN && ms_r == '0) |-> (lin_r == '0 && ang_r == '0))
    else $error("zero elapsed time with nonzero velocity");

  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cres.done |-> (state_r == ST_CW || state_r == ST_QW))
    else $error("CORDIC finished outside a wait state");
`endif

endmodule

@@ src/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle, Q2.30.
// Depends on ddo_pkg (arctangent table, gain, result struct).
module ddo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic [31:0]         ang_i,
  output ddo_pkg::cordic_res_t res_o
);

  localparam int CNT_W = $clog2(STEPS);

  logic                            busy_r;
  logic                            done_r;
  logic                            flip_r;
  logic [CNT_W-1:0]                cnt_r;
  logic signed [ddo_pkg::CW_W-1:0] x_r, y_r, z_r;

  logic [31:0]                     ang_q;
  logic [31:0]                     ang_f;
  logic                            flip_c;
  logic signed [ddo_pkg::CW_W-1:0] xs, ys, at;

  // Fold into [-1/4, 1/4) turn; a half-turn fold negates both outputs
  assign ang_q  = ang_i + 32'h4000_0000;
  assign flip_c = ang_q[31];
  assign ang_f  = flip_c ? ang_i + 32'h8000_0000 : ang_i;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = signed'({2'b00, ddo_pkg::atan_lut(5'(cnt_r))});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Micro-rotation datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      flip_r <= flip_c;
      x_r    <= ddo_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= signed'({{2{ang_f[31]}}, ang_f});
    end else if (busy_r) begin
      if (!z_r[ddo_pkg::CW_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign res_o.done  = done_r;
  assign res_o.cos_v = flip_r ? -x_r : x_r;
  assign res_o.sin_v = flip_r ? -y_r : y_r;

endmodule

@@ src/ddo_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ddo_pkg (operand widths).
module ddo_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [ddo_pkg::NUM_W-1:0] num_i,
  input  logic [ddo_pkg::DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [ddo_pkg::NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(ddo_pkg::NUM_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [ddo_pkg::DEN_W-1:0] den_r;
  logic [ddo_pkg::DEN_W-1:0] rem_r;
  logic [ddo_pkg::NUM_W-1:0] dq_r;

  logic [ddo_pkg::DEN_W:0]   sh;
  logic [ddo_pkg::DEN_W:0]   sub;
  logic                      ge;

  assign sh  = {rem_r, dq_r[ddo_pkg::NUM_W-1]};
  assign ge  = sh >= {1'b0, den_r};
  assign sub = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(ddo_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start_i) begin
      den_r <= den_i;
      rem_r <= '0;
      dq_r  <= num_i;
    end else if (busy_r) begin
      rem_r <= ge ? sub[ddo_pkg::DEN_W-1:0] : sh[ddo_pkg::DEN_W-1:0];
      dq_r  <= {dq_r[ddo_pkg::NUM_W-2:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = dq_r;

endmodule

@@ tb/diff_drive_odometry_check.sv @@
// Checker for diff_drive_odometry_unit: watches the request, result and register ports,
// predicts each result from its own pose model and compares field by field.
// Depends on ddo_pkg for the register indexes, reset values and velocity scale constants.
`timescale 1ns / 100ps

module diff_drive_odometry_check #(
  parameter int STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  in_tdata,   // enc_left, enc_right, elapsed_ms
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,  // pos_x, pos_y, heading_angle, quat_z, quat_w,
                                   // lin_vel, ang_vel
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  // lowest field last, so the struct overlays out_tdata directly
  typedef struct packed {
    logic [31:0] ang_vel;
    logic [31:0] lin_vel;
    logic [15:0] quat_w;
    logic [15:0] quat_z;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  localparam logic [31:0] ARCTAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  localparam longint ROT_GAIN = 64'sd652032874;

  logic [31:0] dist_tick, turn_m;
  logic [31:0] last_l, last_r, x_pos, y_pos, hdg;
  pose_t       expected_poses[$];

  // rotation-mode CORDIC, cos and sin in Q2.30
  task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, nx;
    a = ang + 32'h40000000;
    flip = a[31];
    a = flip ? ang + 32'h80000000 : ang;
    z = longint'($signed(a));
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ARCTAN[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ARCTAN[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // move one axis by dist * trig, saturating
  function automatic logic [31:0] step_axis(input logic [31:0] acc, input logic [127:0] dmag,
                                            input bit dneg, input longint f);
    logic [127:0]        fm, p;
    logic [63:0]         inc;
    logic signed [127:0] v;
    bit                  neg;
    neg = dneg ^ (f < 0);
    fm  = (f < 0) ? 128'(-f) : 128'(f);
    p   = dmag * fm;
    inc = p[109:46];
    v   = $signed({{96{acc[31]}}, acc});
    v   = neg ? v - $signed({64'd0, inc}) : v + $signed({64'd0, inc});
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rate(input logic [127:0] mag, input bit neg,
                                       input logic [31:0] scale, input logic [127:0] den);
    logic [127:0] q;
    logic [127:0] cap;
    cap = neg ? 128'd2147483648 : 128'd2147483647;
    q = (mag * scale) / den;
    if (q > cap) q = cap;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic logic [15:0] q15_of(input longint v);
    longint q;
    q = (v + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic predict_pose(input logic [79:0] req);
    logic [31:0]  el, er, half, mid;
    logic [15:0]  ms;
    longint       dl, dr, sum, diff, c, s;
    bit           dneg, tneg;
    logic [127:0] dmag, wmag, prod;
    logic [63:0]  thmag;
    pose_t        p;
    el = req[31:0];
    er = req[63:32];
    ms = req[79:64];
    dl = longint'($signed(el - last_l));
    dr = longint'($signed(er - last_r));
    sum  = dl + dr;
    diff = dr - dl;
    dneg = sum < 0;
    tneg = diff < 0;
    dmag = (128'(dneg ? -sum : sum) * dist_tick) >> 1;
    wmag = 128'(tneg ? -diff : diff) * dist_tick;
    last_l = el;
    last_r = er;
    prod  = wmag * turn_m;
    thmag = prod[95:32];
    half  = thmag[32:1];
    mid   = tneg ? hdg - half : hdg + half;
    sincos(mid, c, s);
    x_pos = step_axis(x_pos, dmag, dneg, c);
    y_pos = step_axis(y_pos, dmag, dneg, s);
    hdg   = tneg ? hdg - thmag[31:0] : hdg + thmag[31:0];
    sincos({1'b0, hdg[31:1]}, c, s);
    p.pos_x   = x_pos;
    p.pos_y   = y_pos;
    p.heading = hdg;
    p.quat_z  = q15_of(s);
    p.quat_w  = q15_of(c);
    if (ms == 0) begin
      p.lin_vel = '0;
      p.ang_vel = '0;
    end else begin
      p.lin_vel = rate(dmag, dneg, ddo_pkg::LIN_SCALE, 128'(ms) << 16);
      p.ang_vel = rate(128'(thmag), tneg, ddo_pkg::ANG_SCALE, 128'(ms) << 32);
    end
    expected_poses.push_back(p);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 30)
      $display("mismatch at %0t result %0d: %s got %h want %h", $realtime, results_seen,
               what, got, want);
    fail_count++;
  endtask

  task automatic compare_pose(input pose_t got);
    pose_t want;
    if (expected_poses.size() == 0) begin
      report("unexpected result", got.pos_x, 32'd0);
      return;
    end
    want = expected_poses.pop_front();
    if (got.pos_x   !== want.pos_x)   report("pos_x", got.pos_x, want.pos_x);
    if (got.pos_y   !== want.pos_y)   report("pos_y", got.pos_y, want.pos_y);
    if (got.heading !== want.heading) report("heading", got.heading, want.heading);
    if (got.quat_z  !== want.quat_z)  report("quat_z", 32'(got.quat_z), 32'(want.quat_z));
    if (got.quat_w  !== want.quat_w)  report("quat_w", 32'(got.quat_w), 32'(want.quat_w));
    if (got.lin_vel !== want.lin_vel) report("lin_vel", got.lin_vel, want.lin_vel);
    if (got.ang_vel !== want.ang_vel) report("ang_vel", got.ang_vel, want.ang_vel);
  endtask

  // signals are settled at the falling edge and unchanged up to the next rising edge,
  // so what is seen here is what the block sees at that edge
  always @(negedge clk) begin
    if (!rst_n) begin
      dist_tick = ddo_pkg::DIST_PER_TICK_RST;
      turn_m    = ddo_pkg::TURN_PER_METER_RST;
      last_l = '0;
      last_r = '0;
      x_pos  = '0;
      y_pos  = '0;
      hdg    = '0;
      fail_count   = 0;
      results_seen = 0;
      expected_poses.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        compare_pose(pose_t'(out_tdata));
        results_seen++;
      end
      if (cfg_we) begin
        if (cfg_index == ddo_pkg::REG_DIST_PER_TICK) dist_tick = cfg_data;
        else turn_m = cfg_data;
      end
      if (in_tvalid && in_tready) predict_pose(in_tdata);
    end
    pending = expected_poses.size();
  end

endmodule

@@ tb/diff_drive_odometry_unit_test.sv @@
// Top of the odometry testbench: clock, reset, register phases and request traffic.
// Depends on ddo_pkg, diff_drive_odometry_unit and diff_drive_odometry_check.
`timescale 1ns / 100ps

module diff_drive_odometry_unit_test;

  localparam int  PHASE_ITEMS = 200;
  localparam longint CYCLE_LIMIT = 4000000;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [79:0]  in_tdata;   // enc_left, enc_right, elapsed_ms
  logic         out_tvalid, out_tready;
  logic [191:0] out_tdata;  // pos_x, pos_y, heading_angle, quat_z, quat_w, lin_vel, ang_vel
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_data;

  int     fail_count, pending, results_seen;
  logic   in_rdy_s, out_vld_s;
  bit     hold_off;
  int     requests_sent;
  longint cycles;
  logic [31:0] enc_l, enc_r;

  diff_drive_odometry_unit u_dut (.*);

  diff_drive_odometry_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake inputs as they stand before each rising edge
  always @(negedge clk) begin
    in_rdy_s  <= in_tready;
    out_vld_s <= out_tvalid;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        out_tready <= 1'b0;
        held = 1;
        repeat (1500) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_vld_s);
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] l, input logic [31:0] r, input logic [15:0] ms,
                             input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ms, r, l};
    do @(posedge clk); while (!in_rdy_s);
    enc_l = l;
    enc_r = r;
    requests_sent++;
  endtask

  // mostly plausible wheel motion, some wild jumps and raw noise
  task automatic random_sample(input bit burst);
    int          kind;
    logic [31:0] l, r;
    logic [15:0] ms;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      l  = enc_l + 32'($signed($urandom_range(0, 4000)) - 2000);
      r  = enc_r + 32'($signed($urandom_range(0, 4000)) - 2000);
      ms = 16'($urandom_range(20, 250));
    end else if (kind < 9) begin
      l  = enc_l + $urandom();
      r  = enc_r + $urandom();
      ms = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
    end else begin
      l  = $urandom();
      r  = $urandom();
      ms = 16'($urandom());
    end
    send_sample(l, r, ms, burst);
  endtask

  task automatic random_phase(input int n, input bit squeeze);
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) hold_off = 1;
      random_sample(squeeze && i >= n / 2 && i < n / 2 + 20);
    end
    in_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    hold_off  = 0;
    requests_sent = 0;
    enc_l = '0;
    enc_r = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, straight runs, spins, zero and maximum time,
    // count extremes and wrap-around, half-turn heading change
    send_sample(32'd0, 32'd0, 16'd0, 0);
    send_sample(32'd1000, 32'd1000, 16'd100, 0);
    send_sample(32'd2000, 32'd0, 16'd100, 0);
    send_sample(32'd0, 32'd2000, 16'd0, 0);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd65535, 0);
    send_sample(32'h80000000, 32'h80000000, 16'd1, 0);
    send_sample(32'h7FFFFFFF, 32'h80000000, 16'd1, 0);
    send_sample(32'h80000000, 32'h7FFFFFFF, 16'd65535, 0);
    send_sample(32'hFFFFFFFF, 32'h00000000, 16'd1, 0);
    send_sample(32'h00000000, 32'hFFFFFFFF, 16'd1, 0);
    send_sample(32'h00001234, 32'hFFFF0000, 16'd0, 0);
    send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 16'd65535, 0);
    in_tvalid <= 1'b0;
    drain();

    // registers at their maximum: position and velocity saturation
    write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'hFFFFFFFF);
    write_reg(ddo_pkg::REG_TURN_PER_METER, 32'hFFFFFFFF);
    send_sample(enc_l + 32'h7FFFFFFF, enc_r + 32'h7FFFFFFF, 16'd1, 0);
    send_sample(enc_l + 32'h7FFFFFFF, enc_r + 32'h7FFFFFFF, 16'd1, 0);
    send_sample(enc_l + 32'h80000000, enc_r + 32'h80000000, 16'd1, 0);
    send_sample(enc_l + 32'h80000000, enc_r + 32'h80000000, 16'd1, 0);
    send_sample(enc_l + 32'h80000000, enc_r + 32'h7FFFFFFF, 16'd1, 0);
    random_phase(PHASE_ITEMS, 0);

    // zero registers: nothing moves
    write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'd0);
    write_reg(ddo_pkg::REG_TURN_PER_METER, 32'd0);
    random_phase(PHASE_ITEMS / 2, 0);

    // back to defaults with a long receiver stall
    write_reg(ddo_pkg::REG_DIST_PER_TICK, ddo_pkg::DIST_PER_TICK_RST);
    write_reg(ddo_pkg::REG_TURN_PER_METER, ddo_pkg::TURN_PER_METER_RST);
    random_phase(PHASE_ITEMS, 1);

    // random register settings
    for (int p = 0; p < 3; p++) begin
      write_reg(ddo_pkg::REG_DIST_PER_TICK,
                (p == 0) ? $urandom() : 32'($urandom_range(1, 1 << 26)));
      write_reg(ddo_pkg::REG_TURN_PER_METER, $urandom());
      random_phase(PHASE_ITEMS, 0);
    end

    // small step and huge turn rate: heading wraps quickly
    write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'd1);
    write_reg(ddo_pkg::REG_TURN_PER_METER, 32'hFFFFFFFF);
    random_phase(PHASE_ITEMS / 2, 0);
    write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'h40000000);
    write_reg(ddo_pkg::REG_TURN_PER_METER, 32'h00000001);
    random_phase(PHASE_ITEMS / 2, 0);

    $display("sent %0d samples over nine register settings (reset, zero, maximum, random)",
             requests_sent);
    $display("%0d results checked, including a long output stall", results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
